// ----- src/miller_rabin_witness_test_top_macros.svh -----
// Assertion macros for the Miller-Rabin witness test block.
// Included by the modules that carry concurrent assertions.
`ifndef MILLER_RABIN_WITNESS_TEST_TOP_MACROS_SVH
`define MILLER_RABIN_WITNESS_TEST_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset
`define MRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the next cycle
`define MRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mrw_pkg.sv -----
// Package for the Miller-Rabin witness test: payload structs and constants.
// No dependencies.
`default_nettype none
package mrw_pkg;
  localparam int MRW_WIDTH = 128;

  typedef struct packed {
    logic [63:0] base_high;
    logic [63:0] base_low;
    logic [63:0] modulus_high;
    logic [63:0] modulus_low;
  } mrw_in_t;

  typedef struct packed {
    logic bad_modulus;
    logic probable_prime;
  } mrw_out_t;
endpackage
`default_nettype wire

// ----- src/miller_rabin_witness_test_top.sv -----
// Miller-Rabin witness test, one base per item, bit-serial modular multiplier.
// Steps: strip the zeros of n-1, reduce the base, square-and-multiply over d, then squarings.
// One item at a time: a new item is taken only in idle; busy stays high until out_valid.
// An n below 3 goes through S_SPLIT and S_DONE to its result. out_valid lasts one cycle.
// Reset: synchronous active low, clears the sequencer; no clearing pass.
// Depends on mrw_pkg, mrw_mulmod and the assertion macro header.
`default_nettype none
`include "miller_rabin_witness_test_top_macros.svh"
module miller_rabin_witness_test_top import mrw_pkg::*; #(
  parameter int WIDTH = MRW_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire mrw_in_t  in_data,
  output logic          out_valid,
  output mrw_out_t      out_data
);
  localparam int SW = $clog2(WIDTH) + 1;
  localparam int EW = $clog2(WIDTH);

  localparam logic [3:0] S_IDLE = 4'd0, S_SPLIT = 4'd1, S_BASE = 4'd2, S_INIT = 4'd3,
                         S_SQ = 4'd4, S_MUL = 4'd5, S_CHK = 4'd6, S_LOOP = 4'd7,
                         S_DONE = 4'd8;

  logic [3:0]       st_r;
  logic [WIDTH-1:0] n_r, a_r, d_r, x_r, y_r;
  logic [SW-1:0]    s_r, j_r;
  logic [EW-1:0]    e_r;
  logic             pass_r, bad_r, wait_r, ov_r;

  // multiplier interface
  logic             m_start, m_busy, m_done;
  logic [WIDTH-1:0] m_x, m_y, m_r;

  mrw_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .x(m_x), .y(m_y), .n(n_r),
    .busy(m_busy), .done(m_done), .r(m_r)
  );

  logic [127:0] n_in, a_in;
  assign n_in = {in_data.modulus_high, in_data.modulus_low};
  assign a_in = {in_data.base_high, in_data.base_low};

  logic [WIDTH-1:0] nm1, one;
  assign nm1 = n_r - 1'b1;
  assign one = WIDTH'(1);

  // in S_LOOP the multiplier may start only while squarings remain
  logic loop_guard;
  assign loop_guard = (j_r + 1'b1 < s_r);

  // operand select for the shared multiplier
  always_comb begin
    m_start = 1'b0;
    m_x = y_r;
    m_y = y_r;
    if (!wait_r && !m_busy) begin
      case (st_r)
        S_BASE: begin m_start = 1'b1; m_x = one; m_y = a_r; end
        S_INIT: begin m_start = 1'b1; m_x = one; m_y = one; end
        S_SQ:   begin m_start = 1'b1; end
        S_MUL:  begin m_start = 1'b1; m_x = y_r; m_y = x_r; end
        S_LOOP: begin m_start = loop_guard; end
        default: m_start = 1'b0;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      wait_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (m_start) wait_r <= 1'b1;
      else if (m_done) wait_r <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          n_r <= n_in[WIDTH-1:0];
          a_r <= a_in[WIDTH-1:0];
          bad_r <= (n_in[WIDTH-1:0] < WIDTH'(3));
          pass_r <= 1'b0;
          st_r <= S_SPLIT;
        end
        S_SPLIT: begin
          if (bad_r) st_r <= S_DONE;
          else begin
            // find the lowest set bit of n-1, one step a cycle
            d_r <= nm1;
            s_r <= '0;
            st_r <= S_CHK;
            j_r <= '0;
          end
        end
        S_CHK: begin
          // strip trailing zeros (one per cycle)
          if (!d_r[0]) begin
            d_r <= d_r >> 1;
            s_r <= s_r + 1'b1;
          end else st_r <= S_BASE;
        end
        S_BASE: if (m_done) begin
          x_r  <= m_r;
          st_r <= S_INIT;
        end
        S_INIT: if (m_done) begin
          y_r  <= m_r;
          e_r  <= EW'(WIDTH-1);
          st_r <= S_SQ;
        end
        S_SQ: if (m_done) begin
          y_r <= m_r;
          if (d_r[e_r]) st_r <= S_MUL;
          else if (e_r == '0) st_r <= S_LOOP;
          else e_r <= e_r - 1'b1;
          if (!d_r[e_r] && e_r == '0) begin
            if (m_r == one || m_r == nm1) begin
              pass_r <= (m_r == one) || (m_r == nm1);
              st_r <= S_DONE;
            end
          end
        end
        S_MUL: if (m_done) begin
          y_r <= m_r;
          if (e_r == '0) begin
            if (m_r == one || m_r == nm1) begin
              pass_r <= 1'b1;
              st_r <= S_DONE;
            end else st_r <= S_LOOP;
          end else begin
            e_r  <= e_r - 1'b1;
            st_r <= S_SQ;
          end
        end
        S_LOOP: begin
          if (m_done) begin
            y_r <= m_r;
            j_r <= j_r + 1'b1;
            if (m_r == one) st_r <= S_DONE;
            else if (m_r == nm1) begin
              pass_r <= 1'b1;
              st_r <= S_DONE;
            end
          end else if (!wait_r && !m_busy && (j_r + 1'b1 >= s_r)) begin
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data.probable_prime = pass_r && !bad_r;
  assign out_data.bad_modulus = bad_r;

  `MRW_ASSERT_NEXT(a_one_result, clk, rst_n, st_r == S_DONE, out_valid && st_r == S_IDLE, "result not strobed")
  `MRW_ASSERT_IMP(a_bad_verdict, clk, rst_n, out_valid && out_data.bad_modulus, !out_data.probable_prime, "bad modulus with pass")
  `MRW_ASSERT_IMP(a_loop_start, clk, rst_n, m_start && st_r == S_LOOP, loop_guard, "extra squaring")
endmodule
`default_nettype wire

// ----- src/mrw_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on mrw_pkg and the assertion macro header.
`default_nettype none
`include "miller_rabin_witness_test_top_macros.svh"
module mrw_mulmod import mrw_pkg::*; #(
  parameter int WIDTH = MRW_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic [WIDTH-1:0] n,
  output logic                  busy,
  output logic                  done,
  output logic [WIDTH-1:0]      r
);
  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] r_r, r_nxt, x_r, y_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;

  // doubling then conditional add, each with one carry bit
  logic [WIDTH:0] dbl, dsub, sum, ssub;
  logic [WIDTH-1:0] rd;
  always_comb begin
    dbl  = {r_r, 1'b0};
    dsub = dbl - {1'b0, n};
    rd   = (dbl >= {1'b0, n}) ? dsub[WIDTH-1:0] : dbl[WIDTH-1:0];
    sum  = {1'b0, rd} + {1'b0, x_r};
    ssub = sum - {1'b0, n};
    r_nxt = y_r[WIDTH-1] ? ((sum >= {1'b0, n}) ? ssub[WIDTH-1:0] : sum[WIDTH-1:0]) : rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(WIDTH-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      r_r <= '0;
      x_r <= x;
      y_r <= y;
    end else if (busy_r) begin
      r_r <= r_nxt;
      y_r <= {y_r[WIDTH-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign r    = r_r;

  `MRW_ASSERT_NEXT(a_done_ends, clk, rst_n, busy_r && cnt_r == CW'(WIDTH-1), done_r && !busy_r, "mulmod did not finish after WIDTH steps")
  `MRW_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r, "done while busy")
  `MRW_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy_r, busy_r, "start not taken")
endmodule
`default_nettype wire

// ----- tb/mrw_checker.sv -----
// Scoreboard for the Miller-Rabin witness test block: watches both channels,
// predicts each verdict and compares it. Depends on mrw_pkg.
module mrw_checker import mrw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  mrw_in_t  in_data,
  input  logic     out_valid,
  input  mrw_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  mrw_out_t verdicts_due[$];

  // (x * y) mod n, multiplier scanned from the top with one carry bit spare
  function automatic bit [127:0] mod_mul(bit [127:0] x, bit [127:0] y, bit [127:0] n);
    bit [128:0] acc;
    acc = '0;
    for (int i = 127; i >= 0; i--) begin
      acc = acc << 1;
      if (acc >= {1'b0, n}) acc = acc - {1'b0, n};
      if (y[i]) begin
        acc = acc + {1'b0, x};
        if (acc >= {1'b0, n}) acc = acc - {1'b0, n};
      end
    end
    return acc[127:0];
  endfunction

  function automatic mrw_out_t witness_verdict(mrw_in_t item);
    bit [127:0] n, a, nm1, d, x, base;
    int         s;
    mrw_out_t   v;
    n = {item.modulus_high, item.modulus_low};
    a = {item.base_high, item.base_low};
    v = '0;
    if (n < 128'd3) begin
      v.bad_modulus = 1'b1;
      return v;
    end
    nm1 = n - 128'd1;
    d = nm1;
    s = 0;
    while (!d[0] && s < 128) begin
      d = d >> 1;
      s++;
    end
    base = mod_mul(128'd1, a, n);
    // left-to-right square-and-multiply over all exponent bits
    x = mod_mul(128'd1, 128'd1, n);
    for (int i = 127; i >= 0; i--) begin
      x = mod_mul(x, x, n);
      if (d[i]) x = mod_mul(x, base, n);
    end
    if (x == 128'd1 || x == nm1) begin
      v.probable_prime = 1'b1;
    end else begin
      for (int j = 0; j < s - 1; j++) begin
        x = mod_mul(x, x, n);
        if (x == 128'd1) break;
        if (x == nm1) begin
          v.probable_prime = 1'b1;
          break;
        end
      end
    end
    return v;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // predict on each input transfer, compare on each result strobe
  always @(posedge clk) begin
    mrw_out_t want;
    if (rst_n) begin
      if (start && !busy) verdicts_due.push_back(witness_verdict(in_data));
      if (out_valid) begin
        if (verdicts_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %b", out_data);
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.probable_prime !== want.probable_prime ||
              out_data.bad_modulus !== want.bad_modulus) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: prime exp %b got %b, bad_modulus exp %b got %b",
                       want.probable_prime, out_data.probable_prime,
                       want.bad_modulus, out_data.bad_modulus);
          end
        end
      end
      pending = verdicts_due.size();
    end
  end
endmodule

// ----- tb/tb_miller_rabin_witness_test_top.sv -----
// Testbench top for the Miller-Rabin witness test block: clock, reset,
// directed and random candidates, verdict. Depends on mrw_pkg and mrw_checker.
module tb_miller_rabin_witness_test_top import mrw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 30_000_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  mrw_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  mrw_out_t out_data;
  int       fail_count;
  int       pending;
  longint   cycles = 0;
  bit       no_gaps;

  bit [127:0] known_primes[6] = '{
    128'd97, 128'd65537, (128'd1 << 61) - 1, (128'd1 << 64) - 59,
    (128'd1 << 127) - 1, ~128'd0 - 128'd158
  };

  miller_rabin_witness_test_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  mrw_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic bit [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // present one candidate and hold it until the transfer; optional idle after
  task automatic send_candidate(bit [127:0] n, bit [127:0] a);
    int gap;
    start <= 1'b1;
    in_data <= '{base_high: a[127:64], base_low: a[63:0],
                 modulus_high: n[127:64], modulus_low: n[63:0]};
    do @(posedge clk); while (busy);
    if (!no_gaps) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 200);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    bit [127:0] n;
    int pick;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small, even, edge and known cases
    send_candidate(128'd0, 128'd5);
    send_candidate(128'd1, ~128'd0);
    send_candidate(128'd2, 128'd3);
    send_candidate(128'd3, 128'd2);
    send_candidate(128'd4, 128'd3);
    send_candidate(128'd9, 128'd3);
    send_candidate(128'd561, 128'd2);
    send_candidate(128'd97, 128'd0);
    send_candidate(128'd97, 128'd97);
    send_candidate(128'd97, ~128'd0);
    send_candidate((128'd1 << 127) - 1, 128'd3);
    send_candidate((128'd1 << 127) - 1, ~128'd0);
    send_candidate(~128'd0, 128'd2);
    send_candidate(~128'd0 - 128'd158, 128'd7);
    send_candidate(128'd1 << 127, 128'd5);
    send_candidate(~128'd0 - 128'd1, ~128'd0);
    send_candidate((128'd1 << 64) - 59, {64'hffff_ffff_ffff_ffff, 64'd0});

    // random: mostly odd candidates, a share of known primes, some anything
    for (int k = 0; k < 83; k++) begin
      if (k % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 3) n = known_primes[$urandom_range(0, 5)];
      else if (pick < 7) n = rand128() | 128'd1;
      else if (pick < 8) n = $urandom_range(0, 40);
      else n = rand128();
      send_candidate(n, rand128());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
